/* design/yuyv_frame_color_edge_stats_core_macros.svh */
// Assertion macros for the YUYV frame statistics core.
// No dependencies; expects a clock clk and an active-low reset rst_n in scope.
`ifndef YUYV_FRAME_COLOR_EDGE_STATS_CORE_MACROS_SVH
`define YUYV_FRAME_COLOR_EDGE_STATS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define YFCES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define YFCES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define YFCES_ASSERT_NOW(lbl, ante, cons, msg)
`define YFCES_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/yfces_pkg.sv */
// Package for the YUYV frame statistics core: field widths, saturation caps,
// color conversion coefficients and the 8-bit clamp. No dependencies.
package yfces_pkg;

    // Frame size bound that sets the saturation caps
    localparam longint unsigned MAX_PAIRS = 64'd16384;

    // Field widths
    localparam int unsigned PIX_W        = 8;
    localparam int unsigned LUMA_SUM_W   = 23;
    localparam int unsigned RED_SUM_W    = 23;
    localparam int unsigned GB_SUM_W     = 24;
    localparam int unsigned EDGE_TOTAL_W = 16;
    localparam int unsigned PAIR_TOTAL_W = 15;

    // Cap is per-pair maximum times MAX_PAIRS, limited to the field range
    function automatic longint unsigned cap_of(longint unsigned per_pair, int unsigned width);
        longint unsigned lim;
        longint unsigned c;
        lim = (64'd1 << width) - 64'd1;
        c   = per_pair * MAX_PAIRS;
        return (c < lim) ? c : lim;
    endfunction

    localparam logic [LUMA_SUM_W-1:0]   LUMA_CAP = LUMA_SUM_W'(cap_of(64'd510, LUMA_SUM_W));
    localparam logic [RED_SUM_W-1:0]    RED_CAP  = RED_SUM_W'(cap_of(64'd510, RED_SUM_W));
    localparam logic [GB_SUM_W-1:0]     GB_CAP   = GB_SUM_W'(cap_of(64'd1020, GB_SUM_W));
    localparam logic [EDGE_TOTAL_W-1:0] EDGE_CAP = EDGE_TOTAL_W'(cap_of(64'd2, EDGE_TOTAL_W));
    localparam logic [PAIR_TOTAL_W-1:0] PAIR_CAP = PAIR_TOTAL_W'(cap_of(64'd1, PAIR_TOTAL_W));

    // Reset value of the edge threshold
    localparam logic [PIX_W-1:0] EDGE_THRESHOLD_RST = 8'd20;

    // Conversion coefficients, scaled by 1024
    localparam int unsigned PROD_W = 19;
    localparam logic signed [PROD_W-1:0] COEF_RV = 19'sd1436;
    localparam logic signed [PROD_W-1:0] COEF_GU = 19'sd352;
    localparam logic signed [PROD_W-1:0] COEF_GV = 19'sd731;
    localparam logic signed [PROD_W-1:0] COEF_BU = 19'sd1814;
    localparam int unsigned COEF_SHIFT = 10;

    // Width of luma plus a chroma offset, covers -227..479
    localparam int unsigned SUM_PIX_W = 10;

    // Clamp a signed pixel value to 0..255
    function automatic logic [PIX_W-1:0] clamp8(logic signed [SUM_PIX_W-1:0] x);
        logic [PIX_W-1:0] res;
        if (x[SUM_PIX_W-1])
            res = '0;
        else if (x[SUM_PIX_W-2])
            res = '1;
        else
            res = x[PIX_W-1:0];
        return res;
    endfunction

endpackage

/* design/yuyv_frame_color_edge_stats_core.sv */
// Top level of the YUYV frame statistics core: RGB conversion, frame sums and edge count.
// Depends on yfces_pkg and yuyv_frame_color_edge_stats_core_macros.svh.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+----------------------------------------------
//  input    | in_valid / in_stall       | luma_even, chroma_blue, luma_odd, chroma_red,
//           |                           | frame_end
//  output   | out_valid / out_stall     | luma_sum, red_sum, green_blue_sum,
//           |                           | edge_total, pair_total
//  config   | cfg_write_en              | cfg_write_data (edge threshold)
//
// One macropixel per cycle while in_stall is low. A transfer is captured in the input register,
// then converted and added to the frame accumulators; the frame-end pair's totals are
// loaded into the output register when that pair leaves the input register.
// in_stall rises only while a frame-end pair waits in the input register behind a
// result that is still stalled. Reset clears accumulators and valid flags and sets the
// edge threshold to 20.
`include "yuyv_frame_color_edge_stats_core_macros.svh"

module yuyv_frame_color_edge_stats_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_write_en,
    input  logic [yfces_pkg::PIX_W-1:0]           cfg_write_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [yfces_pkg::PIX_W-1:0]           luma_even,
    input  logic [yfces_pkg::PIX_W-1:0]           chroma_blue,
    input  logic [yfces_pkg::PIX_W-1:0]           luma_odd,
    input  logic [yfces_pkg::PIX_W-1:0]           chroma_red,
    input  logic                                  frame_end,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [yfces_pkg::LUMA_SUM_W-1:0]      luma_sum,
    output logic [yfces_pkg::RED_SUM_W-1:0]       red_sum,
    output logic [yfces_pkg::GB_SUM_W-1:0]        green_blue_sum,
    output logic [yfces_pkg::EDGE_TOTAL_W-1:0]    edge_total,
    output logic [yfces_pkg::PAIR_TOTAL_W-1:0]    pair_total
);
    import yfces_pkg::*;

    // Configuration
    logic [PIX_W-1:0] edge_threshold_reg;

    // Input register
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_y0_reg;
    logic [PIX_W-1:0] s1_u_reg;
    logic [PIX_W-1:0] s1_y1_reg;
    logic [PIX_W-1:0] s1_v_reg;
    logic             s1_frame_end_reg;

    // Frame state
    logic [LUMA_SUM_W-1:0]   luma_acc_reg;
    logic [RED_SUM_W-1:0]    red_acc_reg;
    logic [GB_SUM_W-1:0]     gb_acc_reg;
    logic [EDGE_TOTAL_W-1:0] edge_acc_reg;
    logic [PAIR_TOTAL_W-1:0] pair_acc_reg;
    logic [PIX_W-1:0]        prev_luma_reg;
    logic                    frame_started_reg;

    // Result register
    logic                    out_valid_reg;
    logic [LUMA_SUM_W-1:0]   luma_sum_reg;
    logic [RED_SUM_W-1:0]    red_sum_reg;
    logic [GB_SUM_W-1:0]     gb_sum_reg;
    logic [EDGE_TOTAL_W-1:0] edge_total_reg;
    logic [PAIR_TOTAL_W-1:0] pair_total_reg;

    // Handshake
    logic in_take;
    logic s1_fire;

    // Conversion
    logic signed [PIX_W-1:0]     u_s;
    logic signed [PIX_W-1:0]     v_s;
    logic signed [PROD_W-1:0]    u_ext;
    logic signed [PROD_W-1:0]    v_ext;
    logic signed [PROD_W-1:0]    prod_r;
    logic signed [PROD_W-1:0]    prod_g;
    logic signed [PROD_W-1:0]    prod_b;
    logic signed [SUM_PIX_W-1:0] d_r;
    logic signed [SUM_PIX_W-1:0] d_g;
    logic signed [SUM_PIX_W-1:0] d_b;
    logic signed [SUM_PIX_W-1:0] y0_s;
    logic signed [SUM_PIX_W-1:0] y1_s;
    logic [PIX_W-1:0]            r0;
    logic [PIX_W-1:0]            r1;
    logic [PIX_W-1:0]            g0;
    logic [PIX_W-1:0]            g1;
    logic [PIX_W-1:0]            b0;
    logic [PIX_W-1:0]            b1;

    // Per-pair contributions
    logic [PIX_W:0]   luma_pair;
    logic [PIX_W:0]   red_pair;
    logic [PIX_W+1:0] gb_pair;
    logic [PIX_W-1:0] diff_cross;
    logic [PIX_W-1:0] diff_inner;
    logic [1:0]       edge_pair;

    // Saturated sums
    logic [LUMA_SUM_W:0]     luma_raw;
    logic [RED_SUM_W:0]      red_raw;
    logic [GB_SUM_W:0]       gb_raw;
    logic [EDGE_TOTAL_W:0]   edge_raw;
    logic [PAIR_TOTAL_W:0]   pair_raw;
    logic [LUMA_SUM_W-1:0]   luma_next;
    logic [RED_SUM_W-1:0]    red_next;
    logic [GB_SUM_W-1:0]     gb_next;
    logic [EDGE_TOTAL_W-1:0] edge_next;
    logic [PAIR_TOTAL_W-1:0] pair_next;

    // Handshake: a frame-end pair may only move on when the result register frees up
    assign s1_fire  = s1_valid_reg &&
                      (!s1_frame_end_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    // Chroma offset removal: flipping the top bit gives value - 128 as signed
    assign u_s   = signed'(s1_u_reg ^ 8'h80);
    assign v_s   = signed'(s1_v_reg ^ 8'h80);
    assign u_ext = PROD_W'(u_s);
    assign v_ext = PROD_W'(v_s);

    // Chroma terms, floor division by 1024 via arithmetic shift
    assign prod_r = v_ext * COEF_RV;
    assign prod_g = u_ext * COEF_GU + v_ext * COEF_GV;
    assign prod_b = u_ext * COEF_BU;
    assign d_r    = SUM_PIX_W'(prod_r >>> COEF_SHIFT);
    assign d_g    = SUM_PIX_W'(prod_g >>> COEF_SHIFT);
    assign d_b    = SUM_PIX_W'(prod_b >>> COEF_SHIFT);

    // RGB per pixel, clamped
    assign y0_s = signed'({2'b00, s1_y0_reg});
    assign y1_s = signed'({2'b00, s1_y1_reg});
    assign r0   = clamp8(y0_s + d_r);
    assign r1   = clamp8(y1_s + d_r);
    assign g0   = clamp8(y0_s - d_g);
    assign g1   = clamp8(y1_s - d_g);
    assign b0   = clamp8(y0_s + d_b);
    assign b1   = clamp8(y1_s + d_b);

    assign luma_pair = (PIX_W+1)'(s1_y0_reg) + (PIX_W+1)'(s1_y1_reg);
    assign red_pair  = (PIX_W+1)'(r0) + (PIX_W+1)'(r1);
    assign gb_pair   = (PIX_W+2)'(g0) + (PIX_W+2)'(b0) + (PIX_W+2)'(g1) + (PIX_W+2)'(b1);

    // Edge count: across pairs and within the pair, skipped on the first pair of a frame
    assign diff_cross = (s1_y0_reg > prev_luma_reg) ? (s1_y0_reg - prev_luma_reg)
                                                    : (prev_luma_reg - s1_y0_reg);
    assign diff_inner = (s1_y1_reg > s1_y0_reg) ? (s1_y1_reg - s1_y0_reg)
                                                : (s1_y0_reg - s1_y1_reg);
    assign edge_pair  = frame_started_reg
                        ? (2'((diff_cross > edge_threshold_reg))
                           + 2'((diff_inner > edge_threshold_reg)))
                        : 2'd0;

    // Saturating accumulation
    assign luma_raw = {1'b0, luma_acc_reg} + (LUMA_SUM_W+1)'(luma_pair);
    assign red_raw  = {1'b0, red_acc_reg} + (RED_SUM_W+1)'(red_pair);
    assign gb_raw   = {1'b0, gb_acc_reg} + (GB_SUM_W+1)'(gb_pair);
    assign edge_raw = {1'b0, edge_acc_reg} + (EDGE_TOTAL_W+1)'(edge_pair);
    assign pair_raw = {1'b0, pair_acc_reg} + (PAIR_TOTAL_W+1)'(1'b1);

    assign luma_next = (luma_raw > {1'b0, LUMA_CAP}) ? LUMA_CAP : luma_raw[LUMA_SUM_W-1:0];
    assign red_next  = (red_raw > {1'b0, RED_CAP}) ? RED_CAP : red_raw[RED_SUM_W-1:0];
    assign gb_next   = (gb_raw > {1'b0, GB_CAP}) ? GB_CAP : gb_raw[GB_SUM_W-1:0];
    assign edge_next = (edge_raw > {1'b0, EDGE_CAP}) ? EDGE_CAP
                                                     : edge_raw[EDGE_TOTAL_W-1:0];
    assign pair_next = (pair_raw > {1'b0, PAIR_CAP}) ? PAIR_CAP
                                                     : pair_raw[PAIR_TOTAL_W-1:0];

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        else if (cfg_write_en)
            edge_threshold_reg <= cfg_write_data;
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_y0_reg        <= luma_even;
            s1_u_reg         <= chroma_blue;
            s1_y1_reg        <= luma_odd;
            s1_v_reg         <= chroma_red;
            s1_frame_end_reg <= frame_end;
        end
    end

    // Frame accumulators: cleared after the frame-end pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_acc_reg      <= '0;
            red_acc_reg       <= '0;
            gb_acc_reg        <= '0;
            edge_acc_reg      <= '0;
            pair_acc_reg      <= '0;
            prev_luma_reg     <= '0;
            frame_started_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_frame_end_reg)
            begin
                luma_acc_reg      <= '0;
                red_acc_reg       <= '0;
                gb_acc_reg        <= '0;
                edge_acc_reg      <= '0;
                pair_acc_reg      <= '0;
                prev_luma_reg     <= '0;
                frame_started_reg <= 1'b0;
            end
            else
            begin
                luma_acc_reg      <= luma_next;
                red_acc_reg       <= red_next;
                gb_acc_reg        <= gb_next;
                edge_acc_reg      <= edge_next;
                pair_acc_reg      <= pair_next;
                prev_luma_reg     <= s1_y1_reg;
                frame_started_reg <= 1'b1;
            end
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_frame_end_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_frame_end_reg)
        begin
            luma_sum_reg   <= luma_next;
            red_sum_reg    <= red_next;
            gb_sum_reg     <= gb_next;
            edge_total_reg <= edge_next;
            pair_total_reg <= pair_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign luma_sum       = luma_sum_reg;
    assign red_sum        = red_sum_reg;
    assign green_blue_sum = gb_sum_reg;
    assign edge_total     = edge_total_reg;
    assign pair_total     = pair_total_reg;

    // Checks
    `YFCES_ASSERT_NOW(a_stall_only_on_blocked_end, in_stall, s1_valid_reg && s1_frame_end_reg && out_valid_reg && out_stall, "input stalled without a blocked frame-end pair")
    `YFCES_ASSERT_NEXT(a_frame_end_clears, s1_fire && s1_frame_end_reg, out_valid_reg && pair_acc_reg == '0 && !frame_started_reg, "frame end did not emit and clear")
    `YFCES_ASSERT_NOW(a_result_has_pairs, out_valid_reg, pair_total_reg != '0, "result reports an empty frame")
    `YFCES_ASSERT_NOW(a_started_tracks_pairs, 1'b1, frame_started_reg == (pair_acc_reg != '0), "frame start flag out of step with pair count")

endmodule

/* tb/yuyv_frame_color_edge_stats_core_test.sv */
// Testbench for yuyv_frame_color_edge_stats_core: a per-pair frame statistics predictor with
// directed, random and backpressure frames, checked field by field.
// Depends on yfces_pkg and the core RTL.
`timescale 1ns / 1ps

module yuyv_frame_color_edge_stats_core_test;

    localparam int unsigned PIX_W = yfces_pkg::PIX_W;

    // Saturation limits; at MAX_PAIRS = 16384 each product fits its field
    localparam longint unsigned LUMA_LIMIT  = 64'd510 * yfces_pkg::MAX_PAIRS;
    localparam longint unsigned RED_LIMIT   = 64'd510 * yfces_pkg::MAX_PAIRS;
    localparam longint unsigned GB_LIMIT    = 64'd1020 * yfces_pkg::MAX_PAIRS;
    localparam longint unsigned EDGE_LIMIT  = 64'd2 * yfces_pkg::MAX_PAIRS;
    localparam longint unsigned PAIR_LIMIT  = yfces_pkg::MAX_PAIRS;

    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PAIRS    = 800;
    localparam int LONG_HOLD       = 400;

    typedef struct {
        logic [PIX_W-1:0] luma_even;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_odd;
        logic [PIX_W-1:0] chroma_red;
        logic             frame_end;
    } macropixel_t;

    typedef struct {
        logic [yfces_pkg::LUMA_SUM_W-1:0]   luma_sum;
        logic [yfces_pkg::RED_SUM_W-1:0]    red_sum;
        logic [yfces_pkg::GB_SUM_W-1:0]     green_blue_sum;
        logic [yfces_pkg::EDGE_TOTAL_W-1:0] edge_total;
        logic [yfces_pkg::PAIR_TOTAL_W-1:0] pair_total;
    } frame_totals_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write_en;
    logic [PIX_W-1:0]                    cfg_write_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [PIX_W-1:0]                    luma_even;
    logic [PIX_W-1:0]                    chroma_blue;
    logic [PIX_W-1:0]                    luma_odd;
    logic [PIX_W-1:0]                    chroma_red;
    logic                                frame_end;
    logic                                out_valid;
    logic                                out_stall;
    logic [yfces_pkg::LUMA_SUM_W-1:0]    luma_sum;
    logic [yfces_pkg::RED_SUM_W-1:0]     red_sum;
    logic [yfces_pkg::GB_SUM_W-1:0]      green_blue_sum;
    logic [yfces_pkg::EDGE_TOTAL_W-1:0]  edge_total;
    logic [yfces_pkg::PAIR_TOTAL_W-1:0]  pair_total;

    // Predictor state
    logic [PIX_W-1:0] threshold_model;
    longint unsigned  luma_acc_model;
    longint unsigned  red_acc_model;
    longint unsigned  gb_acc_model;
    longint unsigned  edge_acc_model;
    longint unsigned  pair_acc_model;
    logic [PIX_W-1:0] prev_luma_model;
    bit               frame_open;

    frame_totals_t pending_totals[$];
    int            mismatch_count;
    int            idle_cycles;
    int            stall_hold_len;
    int            stall_mode;
    int            stall_mode_left;
    int            burst_left;
    bit            gaps_enabled;

    yuyv_frame_color_edge_stats_core u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .luma_even      (luma_even),
        .chroma_blue    (chroma_blue),
        .luma_odd       (luma_odd),
        .chroma_red     (chroma_red),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .luma_sum       (luma_sum),
        .red_sum        (red_sum),
        .green_blue_sum (green_blue_sum),
        .edge_total     (edge_total),
        .pair_total     (pair_total)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Predictor helpers
    function automatic int unsigned clip_pixel(input int x);
        if (x < 0)
            return 0;
        if (x > 255)
            return 255;
        return x;
    endfunction

    function automatic int unsigned luma_step(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic longint unsigned sat_sum(input longint unsigned acc,
                                               input longint unsigned add,
                                               input longint unsigned limit);
        longint unsigned s;
        s = acc + add;
        return (s > limit) ? limit : s;
    endfunction

    // Fold one macropixel into the frame totals; report totals on frame end
    task automatic accumulate_pair(input macropixel_t p, output bit done,
                                   output frame_totals_t t);
        int          y0;
        int          y1;
        int          u;
        int          v;
        int          dr;
        int          dg;
        int          db;
        int unsigned edges;
        y0 = p.luma_even;
        y1 = p.luma_odd;
        u  = int'(p.chroma_blue) - 128;
        v  = int'(p.chroma_red) - 128;
        // Arithmetic shift gives floor division by 1024
        dr = (1436 * v) >>> 10;
        dg = (352 * u + 731 * v) >>> 10;
        db = (1814 * u) >>> 10;
        edges = 0;
        if (frame_open)
        begin
            if (luma_step(y0, prev_luma_model) > threshold_model)
                edges++;
            if (luma_step(y1, y0) > threshold_model)
                edges++;
        end
        luma_acc_model = sat_sum(luma_acc_model, y0 + y1, LUMA_LIMIT);
        red_acc_model  = sat_sum(red_acc_model,
                                 clip_pixel(y0 + dr) + clip_pixel(y1 + dr), RED_LIMIT);
        gb_acc_model   = sat_sum(gb_acc_model,
                                 clip_pixel(y0 - dg) + clip_pixel(y0 + db) +
                                 clip_pixel(y1 - dg) + clip_pixel(y1 + db), GB_LIMIT);
        edge_acc_model = sat_sum(edge_acc_model, edges, EDGE_LIMIT);
        pair_acc_model = sat_sum(pair_acc_model, 1, PAIR_LIMIT);
        prev_luma_model = p.luma_odd;
        frame_open = 1'b1;
        done = p.frame_end;
        t.luma_sum       = luma_acc_model[yfces_pkg::LUMA_SUM_W-1:0];
        t.red_sum        = red_acc_model[yfces_pkg::RED_SUM_W-1:0];
        t.green_blue_sum = gb_acc_model[yfces_pkg::GB_SUM_W-1:0];
        t.edge_total     = edge_acc_model[yfces_pkg::EDGE_TOTAL_W-1:0];
        t.pair_total     = pair_acc_model[yfces_pkg::PAIR_TOTAL_W-1:0];
        if (p.frame_end)
        begin
            luma_acc_model  = 0;
            red_acc_model   = 0;
            gb_acc_model    = 0;
            edge_acc_model  = 0;
            pair_acc_model  = 0;
            prev_luma_model = '0;
            frame_open      = 1'b0;
        end
    endtask

    // Send one macropixel; idle between bursts when gaps are on
    task automatic send_pair(input macropixel_t p);
        bit            done;
        frame_totals_t t;
        if (gaps_enabled && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid    <= 1'b1;
        luma_even   <= p.luma_even;
        chroma_blue <= p.chroma_blue;
        luma_odd    <= p.luma_odd;
        chroma_red  <= p.chroma_red;
        frame_end   <= p.frame_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_pair(p, done, t);
        if (done)
            pending_totals.insert(pending_totals.size(), t);
    endtask

    // Stop sending and wait until every frame result is back
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [PIX_W-1:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        threshold_model = value;
    endtask

    // Luma either random or a step of the edge threshold or one more, up or down from the base
    function automatic logic [PIX_W-1:0] next_luma(input logic [PIX_W-1:0] base);
        int step;
        int val;
        if ($urandom_range(0, 1) == 0)
            return PIX_W'($urandom_range(0, 255));
        step = int'(threshold_model) + $urandom_range(0, 1);
        val  = ($urandom_range(0, 1) == 0) ? int'(base) + step : int'(base) - step;
        return PIX_W'(clip_pixel(val));
    endfunction

    function automatic macropixel_t random_pair(input bit last);
        macropixel_t p;
        p.luma_even   = next_luma(prev_luma_model);
        p.luma_odd    = next_luma(p.luma_even);
        p.chroma_blue = PIX_W'($urandom_range(0, 255));
        p.chroma_red  = PIX_W'($urandom_range(0, 255));
        p.frame_end   = last;
        return p;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        frame_totals_t t;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_totals.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual luma_sum %0d",
                         $time, luma_sum);
                mismatch_count++;
            end
            else
            begin
                t = pending_totals[0];
                pending_totals.delete(0);
                check_field("luma_sum", t.luma_sum, luma_sum);
                check_field("red_sum", t.red_sum, red_sum);
                check_field("green_blue_sum", t.green_blue_sum, green_blue_sum);
                check_field("edge_total", t.edge_total, edge_total);
                check_field("pair_total", t.pair_total, pair_total);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: long hold on request, else a changing stall pattern
    initial
    begin
        out_stall = 1'b0;
        stall_mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_hold_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_hold_len) @(posedge clk);
                stall_hold_len = 0;
            end
            else
            begin
                if (stall_mode_left == 0)
                begin
                    stall_mode      = $urandom_range(0, 3);
                    stall_mode_left = $urandom_range(16, 96);
                end
                stall_mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Threshold at reset, edge boundaries, first-pair rule, chroma extremes
    task automatic test_directed;
        send_pair('{8'd10, 8'd128, 8'd200, 8'd128, 1'b0});   // first pair: no edges
        send_pair('{8'd220, 8'd128, 8'd200, 8'd128, 1'b0});  // steps equal to threshold
        send_pair('{8'd179, 8'd128, 8'd200, 8'd128, 1'b0});  // steps one above
        send_pair('{8'd0, 8'd0, 8'd255, 8'd0, 1'b1});
        send_pair('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});  // one-pair frame
        send_pair('{8'd0, 8'd255, 8'd0, 8'd0, 1'b0});
        send_pair('{8'd255, 8'd0, 8'd0, 8'd255, 1'b1});
        send_pair('{8'd0, 8'd128, 8'd0, 8'd128, 1'b1});
        // chroma one off center: negative products round down
        send_pair('{8'd128, 8'd127, 8'd128, 8'd129, 1'b1});
        send_pair('{8'd128, 8'd129, 8'd128, 8'd127, 1'b1});
        send_pair('{8'd1, 8'd127, 8'd254, 8'd127, 1'b1});
    endtask

    // Threshold at both ends of its range
    task automatic test_threshold_extremes;
        write_threshold(8'd0);
        send_pair('{8'd50, 8'd128, 8'd50, 8'd128, 1'b0});
        send_pair('{8'd50, 8'd100, 8'd51, 8'd160, 1'b0});
        send_pair('{8'd52, 8'd128, 8'd52, 8'd128, 1'b1});
        write_threshold(8'd255);
        send_pair('{8'd0, 8'd128, 8'd255, 8'd128, 1'b0});
        send_pair('{8'd0, 8'd128, 8'd255, 8'd128, 1'b1});
        write_threshold(8'd20);
    endtask

    // Random frames of mostly short length, threshold changed between some
    task automatic test_random_frames;
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_PAIRS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_threshold(8'd0);
                    1: write_threshold(8'd255);
                    2: write_threshold(PIX_W'($urandom_range(0, 255)));
                    default: write_threshold(PIX_W'($urandom_range(1, 40)));
                endcase
            end
            gaps_enabled = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                send_pair(random_pair(i == len - 1));
            sent += len;
        end
        gaps_enabled = 1'b1;
    endtask

    // Receiver holds off while short frames keep coming, so the input stalls
    task automatic test_backpressure;
        int len;
        write_threshold(PIX_W'($urandom_range(5, 40)));
        gaps_enabled = 1'b0;
        stall_hold_len = LONG_HOLD;
        for (int f = 0; f < 30; f++)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                send_pair(random_pair(i == len - 1));
        end
        gaps_enabled = 1'b1;
        drain();
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        luma_even      = '0;
        chroma_blue    = '0;
        luma_odd       = '0;
        chroma_red     = '0;
        frame_end      = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        stall_hold_len = 0;
        burst_left     = 0;
        gaps_enabled   = 1'b1;
        threshold_model = yfces_pkg::EDGE_THRESHOLD_RST;
        luma_acc_model  = 0;
        red_acc_model   = 0;
        gb_acc_model    = 0;
        edge_acc_model  = 0;
        pair_acc_model  = 0;
        prev_luma_model = '0;
        frame_open      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        test_random_frames();
        test_backpressure();

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_totals.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/yfces_pkg.sv
design/yuyv_frame_color_edge_stats_core.sv
tb/yuyv_frame_color_edge_stats_core_test.sv
